// ----- src/dcr_pkg.sv -----
// ----------------------------------------------------------------------------
// dcr_pkg
// Types, register codes and constants for the disk controller register block.
// ----------------------------------------------------------------------------
package dcr_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam int XFER_WORDS_W     = 9;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic [2:0] REG_STATUS = 3'd0;
   localparam logic [2:0] REG_ERROR  = 3'd1;
   localparam logic [2:0] REG_CTRL   = 3'd2;
   localparam logic [2:0] REG_COUNT  = 3'd3;
   localparam logic [2:0] REG_BUSADR = 3'd4;
   localparam logic [2:0] REG_DSKADR = 3'd5;

   typedef enum logic [2:0] {
      FN_RESET  = 3'd0,
      FN_WRITE  = 3'd1,
      FN_READ   = 3'd2,
      FN_CHECK  = 3'd3,
      FN_SEEK   = 3'd4,
      FN_RDCHK  = 3'd5,
      FN_DRVRST = 3'd6,
      FN_WLOCK  = 3'd7
   } func_type;

   localparam logic [15:0] DRIVE_STATUS_RST = 16'o4700;
   localparam logic [15:0] CTRL_RST         = 16'o0200;
   localparam logic [15:0] DS_READY         = 16'h0040;
   localparam logic [15:0] CS_READY         = 16'h0080;
   localparam logic [15:0] CS_IRQ_EN        = 16'h0040;
   localparam logic [15:0] CS_SEEK_BIT      = 16'h2000;
   localparam logic [15:0] CS_GO_CLEAR      = 16'hfffe;
   localparam logic [15:0] CS_KEEP_MASK     = 16'hf080;
   localparam logic [15:0] ERR_BAD_DRIVE    = 16'h8080;
   localparam logic [15:0] ERR_BAD_CYL      = 16'h8040;
   localparam logic [15:0] ERR_BAD_SECTOR   = 16'h8020;
   localparam logic [15:0] ERR_OVERRUN      = 16'h4000;

   localparam logic [7:0] LAST_CYL         = 8'o312;
   localparam logic [3:0] LAST_SECTOR      = 4'o13;
   localparam int         SECTORS_PER_CYL  = 24;
   localparam int         SECTORS_PER_SURF = 12;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  register_index;
      logic [15:0] write_data;
   } req_type;

   typedef struct packed {
      logic [15:0]             read_data;
      logic                    bad_address;
      logic                    interrupt_request;
      logic                    transfer_start;
      logic                    transfer_to_disk;
      logic [15:0]             transfer_memory_address;
      logic [XFER_WORDS_W-1:0] transfer_words;
      logic [21:0]             transfer_disk_offset;
   } rsp_type;

endpackage

// ----- src/dcr_core.sv -----
// ----------------------------------------------------------------------------
// dcr_core
// Controller registers and the decode of reads, writes and ticks.
// ----------------------------------------------------------------------------
module dcr_core import dcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [15:0] drive_status_ff, drive_status_in;
   logic [15:0] error_bits_ff, error_bits_in;
   logic [15:0] control_status_ff, control_status_in;
   logic [15:0] word_counter_ff, word_counter_in;
   logic [15:0] bus_address_ff, bus_address_in;
   logic [15:0] disk_address_word_ff, disk_address_word_in;
   logic [2:0]  drive_number_ff, drive_number_in;
   logic [7:0]  cylinder_number_ff, cylinder_number_in;
   logic        surface_number_ff, surface_number_in;
   logic [3:0]  sector_number_ff, sector_number_in;

   logic [16:0]             neg_count;
   logic [XFER_WORDS_W-1:0] words;
   logic [12:0]             pos_sector;
   logic [3:0]              sector_inc;
   logic [7:0]              cyl_inc;
   func_type                func;

   always_comb begin
      neg_count  = 17'h10000 - {1'b0, word_counter_ff};
      words      = (neg_count < 17'(WORDS_PER_SECTOR)) ? neg_count[XFER_WORDS_W-1:0]
                                                       : XFER_WORDS_W'(WORDS_PER_SECTOR);
      pos_sector = 13'(cylinder_number_ff) * 13'(SECTORS_PER_CYL)
                 + (surface_number_ff ? 13'(SECTORS_PER_SURF) : 13'd0)
                 + 13'(sector_number_ff);
      sector_inc = sector_number_ff + 4'd1;
      cyl_inc    = cylinder_number_ff + 8'd1;
      func       = func_type'(control_status_ff[3:1]);
   end

   always_comb begin
      drive_status_in      = drive_status_ff;
      error_bits_in        = error_bits_ff;
      control_status_in    = control_status_ff;
      word_counter_in      = word_counter_ff;
      bus_address_in       = bus_address_ff;
      disk_address_word_in = disk_address_word_ff;
      drive_number_in      = drive_number_ff;
      cylinder_number_in   = cylinder_number_ff;
      surface_number_in    = surface_number_ff;
      sector_number_in     = sector_number_ff;
      rsp                  = '0;

      unique case (req.action)
         ACT_READ: begin
            unique case (req.register_index)
               REG_STATUS: rsp.read_data = drive_status_ff;
               REG_ERROR:  rsp.read_data = error_bits_ff;
               REG_CTRL:   rsp.read_data = control_status_ff & CS_GO_CLEAR;
               REG_COUNT:  rsp.read_data = word_counter_ff;
               REG_DSKADR: rsp.read_data = disk_address_word_ff;
               default:    rsp.bad_address = 1'b1;
            endcase
         end
         ACT_WRITE: begin
            unique case (req.register_index)
               REG_CTRL: control_status_in = (req.write_data & ~CS_KEEP_MASK)
                                           | (control_status_ff & CS_KEEP_MASK);
               REG_COUNT:  word_counter_in = req.write_data;
               REG_BUSADR: bus_address_in  = req.write_data;
               REG_DSKADR: begin
                  disk_address_word_in = req.write_data;
                  drive_number_in      = req.write_data[15:13];
                  cylinder_number_in   = req.write_data[12:5];
                  surface_number_in    = req.write_data[4];
                  sector_number_in     = req.write_data[3:0];
               end
               default: rsp.bad_address = 1'b1;
            endcase
         end
         ACT_TICK: begin
            if (control_status_ff[0]) begin
               unique case (func)
                  FN_RESET: begin
                     drive_status_in      = DRIVE_STATUS_RST;
                     error_bits_in        = '0;
                     control_status_in    = CTRL_RST;
                     word_counter_in      = '0;
                     bus_address_in       = '0;
                     disk_address_word_in = '0;
                     drive_number_in      = '0;
                     cylinder_number_in   = '0;
                     surface_number_in    = 1'b0;
                     sector_number_in     = '0;
                  end
                  FN_WRITE, FN_READ, FN_CHECK: begin
                     if (drive_number_ff != 3'd0) begin
                        error_bits_in = error_bits_ff | ERR_BAD_DRIVE;
                     end else if (cylinder_number_ff > LAST_CYL) begin
                        error_bits_in = error_bits_ff | ERR_BAD_CYL;
                     end else if (sector_number_ff > LAST_SECTOR) begin
                        error_bits_in = error_bits_ff | ERR_BAD_SECTOR;
                     end else if (word_counter_ff == 16'd0) begin
                        drive_status_in   = drive_status_ff | DS_READY;
                        control_status_in = (control_status_ff | CS_READY) & CS_GO_CLEAR;
                        rsp.interrupt_request = |(control_status_ff & CS_IRQ_EN);
                     end else begin
                        drive_status_in   = drive_status_ff & ~DS_READY;
                        control_status_in = control_status_ff & ~CS_READY;
                        rsp.transfer_start          = 1'b1;
                        rsp.transfer_to_disk        = (func == FN_WRITE);
                        rsp.transfer_memory_address = bus_address_ff;
                        rsp.transfer_words          = words;
                        rsp.transfer_disk_offset    = {pos_sector, 9'd0};
                        bus_address_in  = bus_address_ff + 16'({words, 1'b0});
                        word_counter_in = word_counter_ff + 16'(words);
                        if (sector_inc > LAST_SECTOR) begin
                           sector_number_in = '0;
                           if (surface_number_ff) begin
                              surface_number_in  = 1'b0;
                              cylinder_number_in = cyl_inc;
                              if (cyl_inc > LAST_CYL) begin
                                 error_bits_in = error_bits_ff | ERR_OVERRUN;
                              end
                           end else begin
                              surface_number_in = 1'b1;
                           end
                        end else begin
                           sector_number_in = sector_inc;
                        end
                     end
                  end
                  FN_SEEK, FN_DRVRST: begin
                     if (func == FN_DRVRST) begin
                        error_bits_in = '0;
                     end
                     control_status_in = ((control_status_ff & ~CS_SEEK_BIT) | CS_READY)
                                       & CS_GO_CLEAR;
                     rsp.interrupt_request = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_status_ff      <= DRIVE_STATUS_RST;
         error_bits_ff        <= '0;
         control_status_ff    <= CTRL_RST;
         word_counter_ff      <= '0;
         bus_address_ff       <= '0;
         disk_address_word_ff <= '0;
         drive_number_ff      <= '0;
         cylinder_number_ff   <= '0;
         surface_number_ff    <= 1'b0;
         sector_number_ff     <= '0;
      end else if (fire) begin
         drive_status_ff      <= drive_status_in;
         error_bits_ff        <= error_bits_in;
         control_status_ff    <= control_status_in;
         word_counter_ff      <= word_counter_in;
         bus_address_ff       <= bus_address_in;
         disk_address_word_ff <= disk_address_word_in;
         drive_number_ff      <= drive_number_in;
         cylinder_number_ff   <= cylinder_number_in;
         surface_number_ff    <= surface_number_in;
         sector_number_ff     <= sector_number_in;
      end
   end

endmodule

// ----- src/disk_controller_registers_top.sv -----
// ----------------------------------------------------------------------------
// disk_controller_registers_top
// Disk controller register block: register access, function decode and
// sector transfer commands, with a registered response.
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload
//  request  | req_valid, req_ready, req_data | req_type: action, index, data
//  response | rsp_valid, rsp_ready, rsp_data | rsp_type: read data, flags, xfer
//
//  One transaction per cycle unless a held response stalls req_ready;
//  the response is registered at accept. The controller registers update
//  at the accept edge, so the next request sees them at once.
//  req_ready is low only while a response is held and rsp_ready is low.
//  Synchronous reset restores the controller registers and empties the
//  response register.
// ----------------------------------------------------------------------------
module disk_controller_registers_top import dcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    fire;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign fire         = req_valid && req_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   dcr_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("request stalled with empty response register");

   a_xfer_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.transfer_start |->
         !rsp_data_ff.transfer_to_disk && rsp_data_ff.transfer_memory_address == '0
         && rsp_data_ff.transfer_words == '0 && rsp_data_ff.transfer_disk_offset == '0)
      else $error("transfer fields set without a transfer");

   a_xfer_words_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.transfer_start |->
         rsp_data_ff.transfer_words != '0
         && rsp_data_ff.transfer_words <= XFER_WORDS_W'(WORDS_PER_SECTOR))
      else $error("transfer word count out of range");

   a_bad_addr_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bad_address |->
         !rsp_data_ff.transfer_start && !rsp_data_ff.interrupt_request)
      else $error("bad address together with a tick result");

endmodule
